[rtl/core/efm_pkg.sv]
// Shared widths, register indexes and fixed-point helpers of the Ewald-sphere frequency map.
package efm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_W  = 16;
    localparam int K_W     = 31;
    localparam int K2_W    = 2 * K_W;
    localparam int ROOT_W  = K_W;
    localparam int MAT_W   = 20;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 31;
    localparam int RND_HALF = 8192;

    typedef enum logic [CFG_IW-1:0] {
        REG_WAVE_NUMBER = 3'd0,
        REG_SIN_PSI     = 3'd1,
        REG_COS_PSI     = 3'd2,
        REG_SIN_TILT    = 3'd3,
        REG_COS_TILT    = 3'd4,
        REG_SIN_PHI     = 3'd5,
        REG_COS_PHI     = 3'd6
    } cfg_index_t;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [MAT_W-1:0]  entry_t;

    typedef struct packed {
        trig_t sin_psi;
        trig_t cos_psi;
        trig_t sin_tilt;
        trig_t cos_tilt;
        trig_t sin_phi;
        trig_t cos_phi;
    } angles_t;

    typedef struct packed {
        entry_t m8;
        entry_t m7;
        entry_t m6;
        entry_t m5;
        entry_t m4;
        entry_t m3;
        entry_t m2;
        entry_t m1;
        entry_t m0;
    } mat_t;

    // a*b rounded to Q1.14, floor of (a*b + 2^13) / 2^14
    function automatic entry_t pm(input entry_t a, input trig_t b);
        logic signed [MAT_W+TRIG_W:0] p;
        begin
            p = a * b + (MAT_W + TRIG_W + 1)'(RND_HALF);
            return p[MAT_W+13:14];
        end
    endfunction

endpackage

[rtl/core/efm_matrix.sv]
// Rotation matrix from the Euler sines and cosines, three register stages.
module efm_matrix
    import efm_pkg::*;
(
    input  logic    clk,
    input  angles_t ang,
    output mat_t    mat
);

    entry_t sfct_reg, cfct_reg, cfcp_reg, cfsp_reg, sfcp_reg, sfsp_reg;
    entry_t sfst_reg, cfst_reg, stsp_reg, stcp_reg, ct1_reg;
    entry_t sfctsp_reg, sfctcp_reg, cfctsp_reg, cfctcp_reg;
    entry_t cfcp2_reg, cfsp2_reg, sfcp2_reg, sfsp2_reg;
    entry_t sfst2_reg, cfst2_reg, stsp2_reg, stcp2_reg, ct2_reg;
    mat_t   mat_reg;
    mat_t   mat_next;

    always_comb
    begin
        mat_next.m0 = cfcp2_reg - sfctsp_reg;
        mat_next.m1 = -cfsp2_reg - sfctcp_reg;
        mat_next.m2 = sfst2_reg;
        mat_next.m3 = sfcp2_reg + cfctsp_reg;
        mat_next.m4 = -sfsp2_reg + cfctcp_reg;
        mat_next.m5 = -cfst2_reg;
        mat_next.m6 = stsp2_reg;
        mat_next.m7 = stcp2_reg;
        mat_next.m8 = ct2_reg;
    end

    // runs freely; settles long before an item reaches the dot products
    always_ff @(posedge clk)
    begin
        sfct_reg <= pm(MAT_W'(ang.sin_phi), ang.cos_tilt);
        cfct_reg <= pm(MAT_W'(ang.cos_phi), ang.cos_tilt);
        cfcp_reg <= pm(MAT_W'(ang.cos_phi), ang.cos_psi);
        cfsp_reg <= pm(MAT_W'(ang.cos_phi), ang.sin_psi);
        sfcp_reg <= pm(MAT_W'(ang.sin_phi), ang.cos_psi);
        sfsp_reg <= pm(MAT_W'(ang.sin_phi), ang.sin_psi);
        sfst_reg <= pm(MAT_W'(ang.sin_phi), ang.sin_tilt);
        cfst_reg <= pm(MAT_W'(ang.cos_phi), ang.sin_tilt);
        stsp_reg <= pm(MAT_W'(ang.sin_tilt), ang.sin_psi);
        stcp_reg <= pm(MAT_W'(ang.sin_tilt), ang.cos_psi);
        ct1_reg  <= MAT_W'(ang.cos_tilt);

        sfctsp_reg <= pm(sfct_reg, ang.sin_psi);
        sfctcp_reg <= pm(sfct_reg, ang.cos_psi);
        cfctsp_reg <= pm(cfct_reg, ang.sin_psi);
        cfctcp_reg <= pm(cfct_reg, ang.cos_psi);
        cfcp2_reg  <= cfcp_reg;
        cfsp2_reg  <= cfsp_reg;
        sfcp2_reg  <= sfcp_reg;
        sfsp2_reg  <= sfsp_reg;
        sfst2_reg  <= sfst_reg;
        cfst2_reg  <= cfst_reg;
        stsp2_reg  <= stsp_reg;
        stcp2_reg  <= stcp_reg;
        ct2_reg    <= ct1_reg;

        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

[rtl/core/efm_sqrt.sv]
// Pipelined integer floor square root, one root bit per stage, with sideband.
module efm_sqrt
    import efm_pkg::*;
#(
    parameter int SIDE_W = 2 * COORD_WIDTH_DEF + 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_v,
    input  logic [K2_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_v,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] out_side
);

    logic [K2_W-1:0]   rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] rt_reg   [0:ROOT_W];
    logic [SIDE_W-1:0] side_reg [0:ROOT_W];
    logic              v_reg    [0:ROOT_W];

    always_comb
    begin
        rem_reg[0]  = radicand;
        rt_reg[0]   = '0;
        side_reg[0] = in_side;
        v_reg[0]    = in_v;
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic [K2_W:0]     trial;
        logic [K2_W-1:0]   rem_next;
        logic [ROOT_W-1:0] rt_next;

        // trial = 2*r*2^B + 2^(2B), r holding only the bits above B
        always_comb
        begin
            trial = ((K2_W+1)'(rt_reg[j]) << (B + 1)) | ((K2_W+1)'(1) << (2 * B));
            if ({1'b0, rem_reg[j]} >= trial)
            begin
                rem_next = rem_reg[j] - trial[K2_W-1:0];
                rt_next  = rt_reg[j] | (ROOT_W'(1) << B);
            end
            else
            begin
                rem_next = rem_reg[j];
                rt_next  = rt_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                rt_reg[j+1]   <= rt_next;
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_v    = v_reg[ROOT_W];
    assign root     = rt_reg[ROOT_W];
    assign out_side = side_reg[ROOT_W];

endmodule

[rtl/core/ewald_sphere_frequency_map_core.sv]
// Top level of the Ewald-sphere frequency map: offset, square root, rotation, output skid.
//
// Input channel: in_valid / in_stall with point_x, point_y, last_point. One detector
// point per beat. Output channel: out_valid / out_stall with freq_x, freq_y, freq_z,
// outside_sphere, last_out; exactly one result per accepted point, in order.
// Configuration: cfg_we / cfg_index / cfg_data write the wave number and the six
// Euler sines and cosines; write them only while no point is in flight.
// Throughput: one point per cycle while in_stall is low. From an accepted input beat
// to out_valid, a point passes the 31-stage square root (one root bit per stage), four
// stages ahead of it for the squares and compare, and the dot products after it.
// Reset clears the registers to wave number 0 and the identity rotation and empties
// the pipeline. When the receiver stalls, the finished result holds on the outputs
// and one more lands in a skid register; only then does in_stall rise, and the whole
// pipeline holds until the skid drains. Nothing is lost or repeated.
module ewald_sphere_frequency_map_core
    import efm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IW-1:0]             cfg_index,
    input  logic [CFG_DW-1:0]             cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] freq_x,
    output logic signed [COORD_WIDTH-1:0] freq_y,
    output logic signed [COORD_WIDTH-1:0] freq_z,
    output logic                          outside_sphere,
    output logic                          last_out
);

    localparam int CW     = COORD_WIDTH;
    localparam int EW     = (CW > 32) ? CW : 32;
    localparam int HW     = EW - 16;
    localparam int HPW    = HW + MAT_W;
    localparam int LPW    = 17 + MAT_W;
    localparam int VW     = HPW + 4;
    localparam int SIDE_W = 2 * CW + 2;
    localparam int OUT_W  = 3 * CW + 2;

    // configuration registers
    logic [K_W-1:0]  wave_number_reg;
    angles_t         ang_reg;
    logic [K2_W-1:0] k2_reg;
    mat_t            mat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_number_reg  <= '0;
            ang_reg.sin_psi  <= '0;
            ang_reg.cos_psi  <= TRIG_W'(16384);
            ang_reg.sin_tilt <= '0;
            ang_reg.cos_tilt <= TRIG_W'(16384);
            ang_reg.sin_phi  <= '0;
            ang_reg.cos_phi  <= TRIG_W'(16384);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_WAVE_NUMBER: wave_number_reg  <= cfg_data[K_W-1:0];
                REG_SIN_PSI:     ang_reg.sin_psi  <= cfg_data[TRIG_W-1:0];
                REG_COS_PSI:     ang_reg.cos_psi  <= cfg_data[TRIG_W-1:0];
                REG_SIN_TILT:    ang_reg.sin_tilt <= cfg_data[TRIG_W-1:0];
                REG_COS_TILT:    ang_reg.cos_tilt <= cfg_data[TRIG_W-1:0];
                REG_SIN_PHI:     ang_reg.sin_phi  <= cfg_data[TRIG_W-1:0];
                REG_COS_PHI:     ang_reg.cos_phi  <= cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        k2_reg <= K2_W'(wave_number_reg) * K2_W'(wave_number_reg);
    end

    efm_matrix u_matrix
    (
        .clk   (clk),
        .ang   (ang_reg),
        .mat   (mat)
    );

    // pipeline runs while the skid is empty
    logic skid_v_reg;
    logic en;
    logic acc;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;
    assign acc      = in_valid && !skid_v_reg;

    // S1: absolute values
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CW-1:0]   x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic            l1_reg, l2_reg, l3_reg, l4_reg;
    logic [EW-1:0]   ax1_reg, ay1_reg;
    logic [EW-1:0]   ax_next, ay_next;
    logic            big2_reg, big3_reg;
    logic [K2_W-1:0] sqx2_reg, sqy2_reg;
    logic [K2_W:0]   rr3_reg;
    logic            out4_reg;
    logic [K2_W-1:0] n4_reg;

    always_comb
    begin
        ax_next = point_x[CW-1] ? EW'(-EW'(point_x)) : EW'(point_x);
        ay_next = point_y[CW-1] ? EW'(-EW'(point_y)) : EW'(point_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= point_x;
            y1_reg  <= point_y;
            l1_reg  <= last_point;
            ax1_reg <= ax_next;
            ay1_reg <= ay_next;

            // S2: squares of the low 31 bits; anything at or above 2^31 is outside
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            l2_reg   <= l1_reg;
            big2_reg <= |ax1_reg[EW-1:31] || |ay1_reg[EW-1:31];
            sqx2_reg <= K2_W'(ax1_reg[30:0]) * K2_W'(ax1_reg[30:0]);
            sqy2_reg <= K2_W'(ay1_reg[30:0]) * K2_W'(ay1_reg[30:0]);

            // S3: x^2 + y^2
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            l3_reg   <= l2_reg;
            big3_reg <= big2_reg;
            rr3_reg  <= (K2_W+1)'(sqx2_reg) + (K2_W+1)'(sqy2_reg);

            // S4: compare against k^2 and form the radicand
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            l4_reg   <= l3_reg;
            out4_reg <= big3_reg || (rr3_reg > (K2_W+1)'(k2_reg));
            n4_reg   <= (big3_reg || (rr3_reg > (K2_W+1)'(k2_reg))) ? '0
                        : K2_W'((K2_W+1)'(k2_reg) - rr3_reg);
        end
    end

    // square root
    logic              vs_v;
    logic [ROOT_W-1:0] vs_root;
    logic [SIDE_W-1:0] vs_side;

    efm_sqrt #(.SIDE_W(SIDE_W)) u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (v4_reg),
        .radicand (n4_reg),
        .in_side  ({x4_reg, y4_reg, out4_reg, l4_reg}),
        .out_v    (vs_v),
        .root     (vs_root),
        .out_side (vs_side)
    );

    // S5: offset t = k - root (zero outside, where the root is taken of 0)
    logic                 v5_reg, v6_reg, v7_reg, v8_reg;
    logic signed [EW-1:0] cx5_reg, cy5_reg, ct5_reg;
    logic                 o5_reg, o6_reg, o7_reg, o8_reg;
    logic                 l5_reg, l6_reg, l7_reg, l8_reg;
    logic                 os_out;
    logic [K_W:0]         t_next;

    assign os_out = vs_side[1];
    assign t_next = os_out ? '0 : ({1'b0, wave_number_reg} - {1'b0, vs_root});

    // D1 products, D2 sums, D3 round and saturate
    logic signed [HPW-1:0] hp6_reg [0:8];
    logic signed [LPW-1:0] lp6_reg [0:8];
    logic signed [HPW+1:0] hs7_reg [0:2];
    logic signed [LPW+1:0] ls7_reg [0:2];
    logic [CW-1:0]         f8_reg  [0:2];
    entry_t                m_arr   [0:8];
    logic signed [EW-1:0]  c_arr   [0:2];

    assign m_arr[0] = mat.m0;
    assign m_arr[1] = mat.m1;
    assign m_arr[2] = mat.m2;
    assign m_arr[3] = mat.m3;
    assign m_arr[4] = mat.m4;
    assign m_arr[5] = mat.m5;
    assign m_arr[6] = mat.m6;
    assign m_arr[7] = mat.m7;
    assign m_arr[8] = mat.m8;
    assign c_arr[0] = cx5_reg;
    assign c_arr[1] = cy5_reg;
    assign c_arr[2] = ct5_reg;

    function automatic logic [CW-1:0] sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] maxv;
        logic signed [VW-1:0] minv;
        begin
            maxv = VW'({1'b0, {(CW-1){1'b1}}});
            minv = -maxv - VW'(1);
            if (v > maxv)
                return maxv[CW-1:0];
            else if (v < minv)
                return minv[CW-1:0];
            else
                return v[CW-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= vs_v;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx5_reg <= EW'($signed(vs_side[2*CW+1:CW+2]));
            cy5_reg <= EW'($signed(vs_side[CW+1:2]));
            ct5_reg <= EW'($signed(t_next));
            o5_reg  <= os_out;
            l5_reg  <= vs_side[0];

            // split each coordinate as hi*2^16 + lo so every product stays narrow
            for (int r = 0; r < 3; r++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hp6_reg[3*r+i] <= HPW'($signed(c_arr[i][EW-1:16])) * HPW'(m_arr[3*r+i]);
                    lp6_reg[3*r+i] <= LPW'($signed({1'b0, c_arr[i][15:0]}))
                                      * LPW'(m_arr[3*r+i]);
                end
            end
            o6_reg <= o5_reg;
            l6_reg <= l5_reg;

            for (int r = 0; r < 3; r++)
            begin
                hs7_reg[r] <= (HPW+2)'(hp6_reg[3*r]) + (HPW+2)'(hp6_reg[3*r+1])
                              + (HPW+2)'(hp6_reg[3*r+2]);
                ls7_reg[r] <= (LPW+2)'(lp6_reg[3*r]) + (LPW+2)'(lp6_reg[3*r+1])
                              + (LPW+2)'(lp6_reg[3*r+2]);
            end
            o7_reg <= o6_reg;
            l7_reg <= l6_reg;

            for (int r = 0; r < 3; r++)
            begin
                f8_reg[r] <= sat((VW'(hs7_reg[r]) <<< 2)
                                 + (VW'(ls7_reg[r] + (LPW+2)'(RND_HALF)) >>> 14));
            end
            o8_reg <= o7_reg;
            l8_reg <= l7_reg;
        end
    end

    // output register and skid
    logic             out_v_reg;
    logic [OUT_W-1:0] out_d_reg;
    logic [OUT_W-1:0] skid_d_reg;
    logic [OUT_W-1:0] p_d;
    logic             out_take;

    assign p_d      = {f8_reg[0], f8_reg[1], f8_reg[2], o8_reg, l8_reg};
    assign out_take = out_v_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_take)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (v8_reg)
        begin
            if (out_v_reg && out_stall)
            begin
                skid_v_reg <= 1'b1;
            end
            out_v_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_take)
            begin
                out_d_reg <= skid_d_reg;
            end
        end
        else if (v8_reg)
        begin
            if (out_v_reg && out_stall)
            begin
                skid_d_reg <= p_d;
            end
            else
            begin
                out_d_reg <= p_d;
            end
        end
    end

    assign out_valid      = out_v_reg;
    assign freq_x         = out_d_reg[3*CW+1:2*CW+2];
    assign freq_y         = out_d_reg[2*CW+1:CW+2];
    assign freq_z         = out_d_reg[CW+1:2];
    assign outside_sphere = out_d_reg[1];
    assign last_out       = out_d_reg[0];

endmodule
